// ===== hdl/spi_encoder_command_sequencer_defines.svh =====
// assertion macros for the encoder spi command sequencer
`ifndef SPI_ENCODER_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_ENCODER_COMMAND_SEQUENCER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SECS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define SECS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/secs_pkg.sv =====
// constants and codes shared by the encoder spi command sequencer
package secs_pkg;

	localparam int ActionW   = 2;
	localparam int ByteW     = 8;
	localparam int StatusW   = 3;
	localparam int PosW      = 12;
	localparam int NibbleW   = 4;
	localparam int PollW     = 8;
	localparam int AttemptW  = 4;
	localparam int CfgIndexW = 1;
	localparam int CfgDataW  = 8;
	localparam int InDataW   = 8;
	localparam int OutDataW  = 24;

	localparam logic [ActionW-1:0] ACT_READ = 2'd0;
	localparam logic [ActionW-1:0] ACT_ZERO = 2'd1;

	localparam logic [ByteW-1:0] CMD_READ  = 8'h10;
	localparam logic [ByteW-1:0] CMD_ZERO  = 8'h70;
	localparam logic [ByteW-1:0] ECHO_ZERO = 8'h80;
	localparam logic [ByteW-1:0] DUMMY     = 8'h00;

	localparam logic [StatusW-1:0] ST_BUSY      = 3'd0;
	localparam logic [StatusW-1:0] ST_POS_OK    = 3'd1;
	localparam logic [StatusW-1:0] ST_READ_FAIL = 3'd2;
	localparam logic [StatusW-1:0] ST_ZERO_OK   = 3'd3;
	localparam logic [StatusW-1:0] ST_ZERO_FAIL = 3'd4;

	localparam logic [CfgIndexW-1:0] REG_POLL_LIMIT    = 1'd0;
	localparam logic [CfgIndexW-1:0] REG_ATTEMPT_LIMIT = 1'd1;

	localparam logic [PollW-1:0]    POLL_LIMIT_RST    = 8'd10;
	localparam logic [AttemptW-1:0] ATTEMPT_LIMIT_RST = 4'd3;
	localparam logic [AttemptW-1:0] ATTEMPT_MAX       = 4'hF;

endpackage

// ===== hdl/spi_encoder_command_sequencer.sv =====
// top level of the encoder spi command sequencer
//
// Host-side sequencer for an absolute encoder's byte-wise spi exchange. A request with
// action 0 starts a position read (command 0x10), action 1 starts a set-zero (command
// 0x70), and any other action carries the byte received for the byte last sent. Every
// request yields exactly one result naming the next byte to send, or, with tlast high,
// the final status and position. One request is taken per clock while the output is
// not stalled; a result passes from the input register through the combinational
// state update into the result register. Both stages are elastic, so a stalled
// result only holds back input once both registers are full.
`include "spi_encoder_command_sequencer_defines.svh"

module spi_encoder_command_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [secs_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [secs_pkg::CfgDataW-1:0]       cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [secs_pkg::InDataW-1:0]        s_tdata,  // rx_byte[7:0]
	input  logic [secs_pkg::ActionW-1:0]        s_tuser,  // action[1:0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [secs_pkg::OutDataW-1:0]       m_tdata,  // send_valid[0], send_byte[8:1],
	                                                      // status[11:9], position[23:12]
	output logic                                m_tlast   // done_res
);
	import secs_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RCMD,
		PH_RPOLL,
		PH_RMSB,
		PH_RLSB,
		PH_RTRAIL,
		PH_ZCMD,
		PH_ZPOLL
	} phase_t;

	// config registers
	logic [PollW-1:0]    poll_limit_q;
	logic [AttemptW-1:0] attempt_limit_q;

	// input stage
	logic               valid_s1;
	logic [ActionW-1:0] action_s1;
	logic [ByteW-1:0]   rx_s1;

	// sequencer state
	phase_t              phase_q;
	logic [PollW-1:0]    poll_cnt_q;
	logic [AttemptW-1:0] err_cnt_q;
	logic [NibbleW-1:0]  hi_q;
	logic [ByteW-1:0]    lo_q;

	// result stage
	logic               valid_s2;
	logic               send_valid_s2;
	logic [ByteW-1:0]   send_byte_s2;
	logic               done_s2;
	logic [StatusW-1:0] status_s2;
	logic [PosW-1:0]    pos_s2;

	// next values
	phase_t              phase_d;
	logic [PollW-1:0]    poll_cnt_d;
	logic [AttemptW-1:0] err_cnt_d;
	logic [AttemptW-1:0] err_inc;
	logic [NibbleW-1:0]  hi_d;
	logic [ByteW-1:0]    lo_d;
	logic                res_send_valid;
	logic [ByteW-1:0]    res_send_byte;
	logic                res_done;
	logic [StatusW-1:0]  res_status;
	logic [PosW-1:0]     res_pos;

	logic out_free;
	logic load_s2;
	logic load_s1;

	assign out_free = !valid_s2 || m_tready;
	assign load_s2  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign load_s1  = s_tvalid && s_tready;

	assign m_tvalid = valid_s2;
	assign m_tlast  = done_s2;
	assign m_tdata  = {pos_s2, status_s2, send_byte_s2, send_valid_s2};

	assign err_inc = (err_cnt_q < ATTEMPT_MAX) ? err_cnt_q + 1'b1 : err_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q    <= POLL_LIMIT_RST;
			attempt_limit_q <= ATTEMPT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLL_LIMIT:    poll_limit_q    <= cfg_data;
				REG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_data[AttemptW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			action_s1 <= s_tuser;
			rx_s1     <= s_tdata;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		poll_cnt_d     = poll_cnt_q;
		err_cnt_d      = err_cnt_q;
		hi_d           = hi_q;
		lo_d           = lo_q;
		res_send_valid = 1'b1;
		res_send_byte  = DUMMY;
		res_done       = 1'b0;
		res_status     = ST_BUSY;
		res_pos        = '0;
		if (action_s1 == ACT_READ) begin
			phase_d       = PH_RCMD;
			poll_cnt_d    = '0;
			err_cnt_d     = '0;
			res_send_byte = CMD_READ;
		end else if (action_s1 == ACT_ZERO) begin
			phase_d       = PH_ZCMD;
			poll_cnt_d    = '0;
			err_cnt_d     = '0;
			res_send_byte = CMD_ZERO;
		end else begin
			unique case (phase_q)
				PH_RCMD: begin
					phase_d    = PH_RPOLL;
					poll_cnt_d = '0;
				end
				PH_RPOLL: begin
					priority if (rx_s1 == CMD_READ) begin
						phase_d = PH_RMSB;
					end else if (poll_cnt_q >= poll_limit_q) begin
						err_cnt_d = err_inc;
						if (err_inc >= attempt_limit_q) begin
							phase_d        = PH_IDLE;
							res_send_valid = 1'b0;
							res_done       = 1'b1;
							res_status     = ST_READ_FAIL;
						end else begin
							phase_d       = PH_RCMD;
							poll_cnt_d    = '0;
							res_send_byte = CMD_READ;
						end
					end else begin
						poll_cnt_d = poll_cnt_q + 1'b1;
					end
				end
				PH_RMSB: begin
					hi_d    = rx_s1[NibbleW-1:0];
					phase_d = PH_RLSB;
				end
				PH_RLSB: begin
					lo_d    = rx_s1;
					phase_d = PH_RTRAIL;
				end
				PH_RTRAIL: begin
					phase_d        = PH_IDLE;
					res_send_valid = 1'b0;
					res_done       = 1'b1;
					res_status     = ST_POS_OK;
					res_pos        = {hi_q, lo_q};
				end
				PH_ZCMD: begin
					phase_d    = PH_ZPOLL;
					poll_cnt_d = '0;
				end
				PH_ZPOLL: begin
					priority if (rx_s1 == ECHO_ZERO) begin
						phase_d        = PH_IDLE;
						res_send_valid = 1'b0;
						res_done       = 1'b1;
						res_status     = ST_ZERO_OK;
					end else if (poll_cnt_q >= poll_limit_q) begin
						phase_d        = PH_IDLE;
						res_send_valid = 1'b0;
						res_done       = 1'b1;
						res_status     = ST_ZERO_FAIL;
					end else begin
						poll_cnt_d = poll_cnt_q + 1'b1;
					end
				end
				default: begin
					// byte while idle gives an all-zero result
					phase_d        = PH_IDLE;
					res_send_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			poll_cnt_q    <= '0;
			err_cnt_q     <= '0;
			hi_q          <= '0;
			lo_q          <= '0;
			valid_s2      <= 1'b0;
			send_valid_s2 <= 1'b0;
			send_byte_s2  <= '0;
			done_s2       <= 1'b0;
			status_s2     <= ST_BUSY;
			pos_s2        <= '0;
		end else begin
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (load_s2) begin
				phase_q       <= phase_d;
				poll_cnt_q    <= poll_cnt_d;
				err_cnt_q     <= err_cnt_d;
				hi_q          <= hi_d;
				lo_q          <= lo_d;
				send_valid_s2 <= res_send_valid;
				send_byte_s2  <= res_send_byte;
				done_s2       <= res_done;
				status_s2     <= res_status;
				pos_s2        <= res_pos;
			end
		end
	end

	`SECS_ASSERT(a_done_stops_send, valid_s2 && done_s2, !send_valid_s2, "done result asks for another byte")
	`SECS_ASSERT(a_pos_only_ok, valid_s2 && (pos_s2 != '0), status_s2 == ST_POS_OK, "position without position ok")
	`SECS_ASSERT_NEXT(a_load_gives_result, load_s2, valid_s2, "processed request produced no result")
	`SECS_ASSERT(a_done_ends_op, load_s2 && res_done, phase_d == PH_IDLE, "finished operation left sequencer busy")

endmodule
